FILE: src/assert_macros.svh
// Assertion macros shared by the read-ahead planner RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/srp_pkg.sv
// Package for the sequential read-ahead planner: beat types, state codes,
// register indexes and fixed field widths. No dependencies.
`default_nettype none
package srp_pkg;

  localparam int OFFSET_BITS = 48;
  localparam int OFF_FIELD_W = OFFSET_BITS;
  localparam int COUNT_W     = 10;
  localparam int CLEN_W      = 25;
  localparam int CHUNK_W     = 24;
  localparam int LEN_W       = 35;
  localparam int RUN_W       = 32;
  localparam int THR_W       = 8;
  localparam int FACTOR_W    = 8;
  localparam int RATE_W      = 10;
  localparam int RATE_SUM_W  = RATE_W + 1;
  localparam int RS_W        = LEN_W + FACTOR_W;
  localparam int QUO_W       = 18;
  localparam int DIV_CNT_W   = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 10;

  localparam logic [DIV_CNT_W-1:0] MOD_STEPS = DIV_CNT_W'(RUN_W);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(QUO_W);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 4'd3;

  typedef struct packed {
    logic [OFF_FIELD_W-1:0] start_offset;
    logic [COUNT_W-1:0]     chunk_count;
    logic [CLEN_W-1:0]      chunk_length;
    logic [OFF_FIELD_W-1:0] object_size;
  } srp_req_t;

  typedef struct packed {
    logic [OFF_FIELD_W-1:0] prefetch_offset;
    logic [OFF_FIELD_W-1:0] prefetch_bytes;
    logic [CHUNK_W-1:0]     prefetch_chunks;
    logic                   is_sequential;
    logic                   stream_detected;
  } srp_res_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } srp_div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srp_div_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_EVAL,
    ST_MOD_GO,
    ST_MOD,
    ST_CLIP,
    ST_DIV_GO,
    ST_DIV,
    ST_OUT
  } srp_state_t;

endpackage
`default_nettype wire

FILE: src/srp_divider.sv
// Shared restoring divider, one quotient bit per cycle, for the planner.
// Depends on srp_pkg for widths and the command and status structs.
`default_nettype none
module srp_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire srp_pkg::srp_div_cmd_t     cmd,
  input  wire logic [srp_pkg::CLEN_W-1:0] rem_init,
  input  wire logic [srp_pkg::RUN_W-1:0]  dividend,
  input  wire logic [srp_pkg::CLEN_W-1:0] divisor,
  output srp_pkg::srp_div_sts_t           sts,
  output logic [srp_pkg::CLEN_W-1:0]      rem,
  output logic [srp_pkg::QUO_W-1:0]       quo
);
  import srp_pkg::*;

  logic [RUN_W-1:0]     dvd;
  logic [CLEN_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [CLEN_W:0]      ext;
  logic [CLEN_W+1:0]    trial;

  assign ext   = {rem, dvd[RUN_W-1]};
  assign trial = {1'b0, ext} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= rem_init;
      dvd <= dividend;
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[RUN_W-2:0], 1'b0};
      if (!trial[CLEN_W+1]) begin
        rem <= trial[CLEN_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= ext[CLEN_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule
`default_nettype wire

FILE: src/sequential_readahead_planner_core.sv
// A disabled block, or a request that fails an early check, gives its result sooner than
// a full read-ahead, which waits on the divider before its result is given.
// Requests are taken one at a time: a new request is not taken until the result has gone out.
// The shared one-bit-per-cycle divider runs 32 steps for the period
// check and 18 for the chunk count. Reset is synchronous; it restores register defaults
// and clears the stream history. Depends on srp_pkg, srp_divider and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sequential_readahead_planner_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire srp_pkg::srp_req_t              req_data,
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output srp_pkg::srp_res_t                   res_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srp_pkg::*;

  localparam int SUM_W = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
  localparam int SEQ_W = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;
  localparam int CMP_W = (OFFSET_BITS > RS_W) ? OFFSET_BITS : RS_W;

  srp_state_t phase;
  srp_state_t phase_next;

  logic                 cfg_enable;
  logic [THR_W-1:0]     cfg_threshold;
  logic [FACTOR_W-1:0]  cfg_factor;
  logic [RATE_W-1:0]    cfg_rate;

  logic [OFFSET_BITS-1:0] last_offset;
  logic [LEN_W-1:0]       last_length;
  logic [RUN_W-1:0]       run_count;

  srp_req_t               req_r;
  logic [LEN_W-1:0]       len_r;
  logic [RS_W-1:0]        raw_r;
  logic [SUM_W-1:0]       ra_off_r;
  logic [RS_W-1:0]        ra_size_r;
  logic [QUO_W-1:0]       chunks_r;
  logic                   seq_r;
  logic                   det_r;
  logic                   pf_ok;

  logic [OFFSET_BITS-1:0] off_w;
  logic [OFFSET_BITS-1:0] end_w;
  logic [OFFSET_BITS-1:0] off_delta;
  logic                   seq;
  logic [LEN_W-1:0]       len_prod;
  logic [FACTOR_W-1:0]    factor_eff;
  logic [FACTOR_W-1:0]    factor_m1;
  logic                   detected;
  logic                   rate_fail;
  logic                   clip_bad;
  logic [OFFSET_BITS-1:0] room;
  logic [CMP_W-1:0]       room_x;
  logic [CMP_W-1:0]       raw_x;
  logic [RS_W-1:0]        clip_size;

  srp_div_cmd_t           div_cmd;
  srp_div_sts_t           div_sts;
  logic [CLEN_W-1:0]      div_rem_init;
  logic [RUN_W-1:0]       div_dividend;
  logic [CLEN_W-1:0]      div_divisor;
  logic [CLEN_W-1:0]      div_rem;
  logic [QUO_W-1:0]       div_quo;
  logic                   req_beat;

  assign cfg_ready = 1'b1;
  assign req_beat  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enable    <= 1'b1;
      cfg_threshold <= THR_W'(2);
      cfg_factor    <= FACTOR_W'(2);
      cfg_rate      <= RATE_W'(128);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:    cfg_enable    <= cfg_data[0];
        REG_THRESHOLD: cfg_threshold <= cfg_data[THR_W-1:0];
        REG_FACTOR:    cfg_factor    <= cfg_data[FACTOR_W-1:0];
        REG_RATE:      cfg_rate      <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign off_w      = OFFSET_BITS'(req_r.start_offset);
  assign end_w      = OFFSET_BITS'(req_r.object_size);
  assign off_delta  = off_w - last_offset;
  assign seq        = (off_w >= last_offset) &&
                      (SEQ_W'(off_delta) == SEQ_W'(last_length));
  assign len_prod   = LEN_W'(req_r.chunk_count) * LEN_W'(req_r.chunk_length);
  assign factor_eff = (cfg_factor == '0) ? FACTOR_W'(1) : cfg_factor;
  assign factor_m1  = (cfg_factor == '0) ? '0 : cfg_factor - 1'b1;
  assign detected   = run_count >= RUN_W'(cfg_threshold);
  assign rate_fail  = (RATE_SUM_W'(req_r.chunk_count) + RATE_SUM_W'(factor_eff)) >=
                      {cfg_rate, 1'b0};

  assign clip_bad   = (ra_off_r[SUM_W-1:OFFSET_BITS] != '0) ||
                      (ra_off_r[OFFSET_BITS-1:0] > end_w);
  assign room       = end_w - ra_off_r[OFFSET_BITS-1:0];
  assign room_x     = CMP_W'(room);
  assign raw_x      = CMP_W'(raw_r);
  assign clip_size  = clip_bad ? '0 :
                      ((raw_x >= room_x) ? RS_W'(room_x) : raw_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ST_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      ST_IDLE: begin
        if (req_valid) begin
          phase_next = cfg_enable ? ST_LEN : ST_OUT;
        end
      end
      ST_LEN:  phase_next = ST_EVAL;
      ST_EVAL: begin
        if (!detected || rate_fail || (end_w == '0)) begin
          phase_next = ST_OUT;
        end else begin
          phase_next = ST_MOD_GO;
        end
      end
      ST_MOD_GO: phase_next = ST_MOD;
      ST_MOD: begin
        if (div_sts.done) begin
          phase_next = (div_rem != '0) ? ST_OUT : ST_CLIP;
        end
      end
      ST_CLIP: phase_next = ST_DIV_GO;
      ST_DIV_GO: phase_next = (ra_size_r == '0) ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (div_sts.done) begin
          phase_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_stall) begin
          phase_next = ST_IDLE;
        end
      end
      default: phase_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall     = 1'b1;
    res_valid     = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.steps = MOD_STEPS;
    div_rem_init  = '0;
    div_dividend  = run_count - RUN_W'(cfg_threshold);
    div_divisor   = CLEN_W'(factor_eff);
    case (phase)
      ST_IDLE:   req_stall = 1'b0;
      ST_MOD_GO: div_cmd.start = 1'b1;
      ST_DIV_GO: begin
        div_cmd.start = (ra_size_r != '0);
        div_cmd.steps = DIV_STEPS;
        div_rem_init  = ra_size_r[RS_W-1:QUO_W];
        div_dividend  = {ra_size_r[QUO_W-1:0], (RUN_W - QUO_W)'(0)};
        div_divisor   = req_r.chunk_length;
      end
      ST_OUT:    res_valid = 1'b1;
      default: ;
    endcase
  end

  // The quotient is at most count * (factor - 1) < 2**18, so the top bits of the
  // clipped size are already below the chunk length and preload the remainder.
  srp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_offset <= '0;
      last_length <= '0;
      run_count   <= '0;
    end else if (phase == ST_LEN) begin
      last_offset <= off_w;
      last_length <= len_prod;
      if (seq) begin
        if (run_count != '1) begin
          run_count <= run_count + 1'b1;
        end
      end else begin
        run_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_r <= 1'b0;
      det_r <= 1'b0;
      pf_ok <= 1'b0;
    end else begin
      case (phase)
        ST_IDLE: begin
          if (req_beat) begin
            seq_r <= 1'b0;
            det_r <= 1'b0;
            pf_ok <= 1'b0;
          end
        end
        ST_LEN:  seq_r <= seq;
        ST_EVAL: det_r <= detected;
        ST_DIV: begin
          if (div_sts.done) begin
            pf_ok <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      req_r <= req_data;
    end
    if (phase == ST_LEN) begin
      len_r <= len_prod;
    end
    if (phase == ST_EVAL) begin
      raw_r    <= RS_W'(len_r) * RS_W'(factor_m1);
      ra_off_r <= SUM_W'(off_w) + SUM_W'(len_r);
    end
    if (phase == ST_CLIP) begin
      ra_size_r <= clip_size;
    end
    if ((phase == ST_DIV) && div_sts.done) begin
      chunks_r <= div_quo;
    end
  end

  always_comb begin
    res_data.is_sequential   = seq_r;
    res_data.stream_detected = det_r;
    res_data.prefetch_offset = '0;
    res_data.prefetch_bytes  = '0;
    res_data.prefetch_chunks = '0;
    if (pf_ok) begin
      res_data.prefetch_offset = OFF_FIELD_W'(ra_off_r[OFFSET_BITS-1:0]);
      res_data.prefetch_bytes  = OFF_FIELD_W'(ra_size_r);
      res_data.prefetch_chunks = CHUNK_W'(chunks_r);
    end
  end

  `SRP_ASSERT_IMP(a_no_req_while_res, res_valid, req_stall,
                  "request taken while a result is pending")
  `SRP_ASSERT_IMP(a_zero_size_clean,
                  res_valid && (res_data.prefetch_bytes == '0),
                  (res_data.prefetch_chunks == '0) && (res_data.prefetch_offset == '0),
                  "read-ahead offset or chunks without a size")
  `SRP_ASSERT_IMP(a_size_needs_stream,
                  res_valid && !res_data.stream_detected,
                  res_data.prefetch_bytes == '0,
                  "read-ahead given without a detected stream")
  `SRP_ASSERT_IMP(a_div_busy_state, div_sts.busy,
                  (phase == ST_MOD) || (phase == ST_DIV),
                  "divider running outside its wait states")

endmodule
`default_nettype wire
